// ===== src/handheld_bus_decoder_cart_addresser_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bus decoder / cartridge addresser
// Concurrent checks that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef HANDHELD_BUS_DECODER_CART_ADDRESSER_MACROS_SVH
`define HANDHELD_BUS_DECODER_CART_ADDRESSER_MACROS_SVH

`ifndef SYNTHESIS
// check with reset disable
`define HBDCA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that also holds in reset
`define HBDCA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HBDCA_ASSERT(lbl, clk, rst, prop, msg)
`define HBDCA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== src/hbdca_pkg.sv =====
// ----------------------------------------------------------------------------
// hbdca_pkg
// Types, register indexes and bus map constants of the bus decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hbdca_pkg;

  localparam int POS_BITS       = 20;
  localparam int ADDR_BITS      = 16;
  localparam int BYTE_BITS      = 8;
  localparam int PAGE_BITS      = 12;
  localparam int CART_BITS      = 21;
  localparam int LOC_BITS       = 21;
  localparam int PROD_BITS      = BYTE_BITS + PAGE_BITS;
  localparam int SUM_BITS       = ((PROD_BITS > POS_BITS) ? PROD_BITS : POS_BITS) + 1;
  localparam int CFG_DATA_BITS  = 21;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  localparam logic [CFG_INDEX_BITS-1:0] CFG_PAGE_SIZE  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CART_BYTES = 1'b1;

  localparam logic [PAGE_BITS-1:0] PAGE_SIZE_RESET = 12'd2048;

  localparam logic [ADDR_BITS-1:0] ADDR_CART_PORT = 16'hFCB2;
  localparam logic [ADDR_BITS-1:0] ADDR_MAP_CTL   = 16'hFFF9;
  localparam logic [ADDR_BITS-1:0] ADDR_BOOT_BASE = 16'hFE00;
  localparam logic [ADDR_BITS-1:0] ADDR_VECTORS   = 16'hFFFA;
  localparam logic [ADDR_BITS-1:0] ADDR_BOOT_HOLE = 16'hFFF8;
  localparam logic [ADDR_BITS-1:0] ADDR_IO_DATA   = 16'hFD8B;
  localparam logic [ADDR_BITS-1:0] ADDR_STROBE    = 16'hFD87;
  localparam logic [ADDR_BITS-1:0] ADDR_DISP_LO   = 16'hFD94;
  localparam logic [ADDR_BITS-1:0] ADDR_DISP_HI   = 16'hFD95;

  localparam int MAPCTL_VEC_RAM_BIT  = 3;
  localparam int MAPCTL_BOOT_RAM_BIT = 2;

  localparam logic [BYTE_BITS-1:0] MISS_BYTE = 8'hFF;

  typedef enum logic {
    MODE_READ  = 1'b0,
    MODE_WRITE = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    ROUTE_CART   = 3'd0,
    ROUTE_MISS   = 3'd1,
    ROUTE_MAPCTL = 3'd2,
    ROUTE_BOOT   = 3'd3,
    ROUTE_MEM    = 3'd4
  } route_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] map_control;
    logic                 io_data_bit;
    logic                 strobe_level;
    logic [POS_BITS-1:0]  cart_position;
    logic [PROD_BITS-1:0] addr_base;
    logic [CART_BITS-1:0] cart_bytes;
  } state_t;

  typedef struct packed {
    logic                 map_we;
    logic [BYTE_BITS-1:0] map_val;
    logic                 io_we;
    logic                 io_val;
    logic                 strobe_we;
    logic                 strobe_val;
    logic                 shift_step;
    logic                 pos_inc;
  } update_t;

  typedef struct packed {
    route_t               route;
    logic [LOC_BITS-1:0]  location;
    logic [BYTE_BITS-1:0] read_value;
    logic                 forward_write;
    logic                 display_flip;
  } result_t;

endpackage

`default_nettype wire

// ===== src/hbdca_access_if.sv =====
// ----------------------------------------------------------------------------
// hbdca_access_if
// Valid/ready channel carrying one CPU bus access per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface hbdca_access_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] address;
  logic [7:0]  write_byte;

  modport source (output valid, mode, address, write_byte, input ready);
  modport sink (input valid, mode, address, write_byte, output ready);
endinterface

`default_nettype wire

// ===== src/hbdca_result_if.sv =====
// ----------------------------------------------------------------------------
// hbdca_result_if
// Valid/ready channel carrying one routing result per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface hbdca_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  route;
  logic [20:0] location;
  logic [7:0]  read_value;
  logic        forward_write;
  logic        display_flip;

  modport source (output valid, route, location, read_value, forward_write, display_flip,
                  input ready);
  modport sink (input valid, route, location, read_value, forward_write, display_flip,
                output ready);
endinterface

`default_nettype wire

// ===== src/hbdca_regs.sv =====
// ----------------------------------------------------------------------------
// hbdca_regs
// Config registers, map/strobe/shift/position state and the registered
// cartridge block base (shift * page size).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hbdca_regs (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write_en,
  input  wire logic [hbdca_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [hbdca_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                                 accept,
  input  wire hbdca_pkg::update_t                   upd,
  output hbdca_pkg::state_t                         st
);
  import hbdca_pkg::*;

  logic [PAGE_BITS-1:0] page_size;
  logic [PAGE_BITS-1:0] page_size_next;
  logic [CART_BITS-1:0] cart_bytes;
  logic [BYTE_BITS-1:0] map_control;
  logic                 io_data_bit;
  logic                 strobe_level;
  logic [BYTE_BITS-1:0] cart_block_shift;
  logic [BYTE_BITS-1:0] cart_block_shift_next;
  logic [POS_BITS-1:0]  cart_position;
  logic [PROD_BITS-1:0] addr_base;

  always_comb begin
    page_size_next = page_size;
    if (cfg_write_en && cfg_index == CFG_PAGE_SIZE) begin
      page_size_next = cfg_data[PAGE_BITS-1:0];
    end
    cart_block_shift_next = cart_block_shift;
    if (accept && upd.shift_step) begin
      cart_block_shift_next = {cart_block_shift[BYTE_BITS-2:0], io_data_bit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_size  <= PAGE_SIZE_RESET;
      cart_bytes <= '0;
    end else if (cfg_write_en) begin
      page_size <= page_size_next;
      if (cfg_index == CFG_CART_BYTES) begin
        cart_bytes <= cfg_data[CART_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_control      <= '0;
      io_data_bit      <= 1'b0;
      strobe_level     <= 1'b0;
      cart_block_shift <= '0;
      cart_position    <= '0;
      addr_base        <= '0;
    end else begin
      cart_block_shift <= cart_block_shift_next;
      // base tracks next shift and page size so the following beat sees it
      addr_base <= PROD_BITS'(cart_block_shift_next) * PROD_BITS'(page_size_next);
      if (accept) begin
        if (upd.map_we) begin
          map_control <= upd.map_val;
        end
        if (upd.io_we) begin
          io_data_bit <= upd.io_val;
        end
        if (upd.strobe_we) begin
          strobe_level <= upd.strobe_val;
        end
        if (upd.shift_step) begin
          cart_position <= '0;
        end else if (upd.pos_inc && cart_position != POS_MAX) begin
          cart_position <= cart_position + POS_BITS'(1);
        end
      end
    end
  end

  assign st.map_control   = map_control;
  assign st.io_data_bit   = io_data_bit;
  assign st.strobe_level  = strobe_level;
  assign st.cart_position = cart_position;
  assign st.addr_base     = addr_base;
  assign st.cart_bytes    = cart_bytes;

endmodule

`default_nettype wire

// ===== src/hbdca_decode.sv =====
// ----------------------------------------------------------------------------
// hbdca_decode
// Single-pass access decode: routing result and state updates for one beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hbdca_decode (
  input  wire logic                            mode,
  input  wire logic [hbdca_pkg::ADDR_BITS-1:0] address,
  input  wire logic [hbdca_pkg::BYTE_BITS-1:0] write_byte,
  input  wire hbdca_pkg::state_t               st,
  output hbdca_pkg::result_t                   res,
  output hbdca_pkg::update_t                   upd
);
  import hbdca_pkg::*;

  logic [SUM_BITS-1:0] cart_addr;
  logic                cart_hit;
  logic                as_ram;

  always_comb begin
    cart_addr = SUM_BITS'(st.addr_base) + SUM_BITS'(st.cart_position);
    cart_hit  = cart_addr < SUM_BITS'(st.cart_bytes);
    as_ram    = (address >= ADDR_VECTORS) ? st.map_control[MAPCTL_VEC_RAM_BIT]
                                          : st.map_control[MAPCTL_BOOT_RAM_BIT];

    res.route         = ROUTE_MEM;
    res.location      = LOC_BITS'(address);
    res.read_value    = '0;
    res.forward_write = 1'b0;
    res.display_flip  = 1'b0;

    upd.map_we     = 1'b0;
    upd.map_val    = write_byte;
    upd.io_we      = 1'b0;
    upd.io_val     = write_byte[1];
    upd.strobe_we  = 1'b0;
    upd.strobe_val = write_byte[0];
    upd.shift_step = 1'b0;
    upd.pos_inc    = 1'b0;

    if (mode == MODE_READ) begin
      if (address == ADDR_CART_PORT) begin
        upd.pos_inc = 1'b1;
        if (cart_hit) begin
          res.route    = ROUTE_CART;
          res.location = cart_addr[LOC_BITS-1:0];
        end else begin
          res.route      = ROUTE_MISS;
          res.location   = '0;
          res.read_value = MISS_BYTE;
        end
      end else if (address == ADDR_MAP_CTL) begin
        res.route      = ROUTE_MAPCTL;
        res.location   = '0;
        res.read_value = st.map_control;
      end else if (address >= ADDR_BOOT_BASE && !as_ram && address != ADDR_BOOT_HOLE) begin
        res.route    = ROUTE_BOOT;
        res.location = LOC_BITS'(address - ADDR_BOOT_BASE);
      end
    end else begin
      res.forward_write = 1'b1;
      if (address == ADDR_IO_DATA) begin
        upd.io_we = 1'b1;
      end else if (address == ADDR_STROBE) begin
        upd.strobe_we  = 1'b1;
        upd.shift_step = write_byte[0] && !st.strobe_level;
      end else if (address == ADDR_DISP_LO || address == ADDR_DISP_HI) begin
        res.display_flip = 1'b1;
      end else if (address == ADDR_MAP_CTL) begin
        upd.map_we = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/handheld_bus_decoder_cart_addresser.sv =====
// ----------------------------------------------------------------------------
// handheld_bus_decoder_cart_addresser
// Routes CPU bus accesses to cartridge, cartridge miss, boot ROM, map control or main memory.
//
//   channel   dir   beat content
//   access    in    mode, address, write_byte
//   result    out   route, location, read_value, forward_write, display_flip
//   cfg       in    cfg_write_en, cfg_index, cfg_data (no handshake)
//
// One access per cycle unless stalled; its result sits in the output
// register from the cycle after the access beat. The cartridge base
// (block * page size) is a registered multiply ahead of the decode.
// Output stall holds the result and drops access.ready only while the
// result register is full and not taken. Reset: one cycle, rst high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "handheld_bus_decoder_cart_addresser_macros.svh"

module handheld_bus_decoder_cart_addresser (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write_en,
  input  wire logic [hbdca_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [hbdca_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  hbdca_access_if.sink                              access,
  hbdca_result_if.source                            result
);
  import hbdca_pkg::*;

  logic    accept;
  logic    out_valid;
  result_t out_res;
  result_t res;
  update_t upd;
  state_t  st;

  assign access.ready = !out_valid || result.ready;
  assign accept       = access.valid && access.ready;

  hbdca_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .upd          (upd),
    .st           (st)
  );

  hbdca_decode u_decode (
    .mode       (access.mode),
    .address    (access.address),
    .write_byte (access.write_byte),
    .st         (st),
    .res        (res),
    .upd        (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res <= res;
    end
  end

  assign result.valid         = out_valid;
  assign result.route         = out_res.route;
  assign result.location      = out_res.location;
  assign result.read_value    = out_res.read_value;
  assign result.forward_write = out_res.forward_write;
  assign result.display_flip  = out_res.display_flip;

  `HBDCA_ASSERT(a_miss_byte, clk, rst, result.valid && out_res.route == ROUTE_MISS |-> result.read_value == MISS_BYTE, "cartridge miss without 0xFF")
  `HBDCA_ASSERT(a_fwd_mem, clk, rst, result.valid && result.forward_write |-> out_res.route == ROUTE_MEM, "forwarded write not routed to memory")
  `HBDCA_ASSERT(a_flip_write, clk, rst, result.valid && result.display_flip |-> result.forward_write, "display flip on a read")
  `HBDCA_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !result.valid, "result valid right after reset")

endmodule

`default_nettype wire
